// ===== rtl/core/stc_pkg.sv =====
`timescale 1ns / 1ps

package stc_pkg;

  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam logic [63:0] MASK_RESET = 64'h0000_0001_0000_2400;

  localparam int unsigned QDepth = 2;
  localparam int unsigned ResMax = 3;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_MARK = 1'b1;

  localparam logic [0:0] REG_SEPARATOR_MASK = 1'b0;

  typedef enum logic [4:0] {
    MODE_SKIP    = 5'b00001,
    MODE_SLASH   = 5'b00010,
    MODE_COMMENT = 5'b00100,
    MODE_QUOTE   = 5'b01000,
    MODE_WORD    = 5'b10000
  } mode_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } res_t;

  // up to three results caused by one input byte
  typedef struct packed {
    logic [1:0]       cnt;
    res_t [ResMax-1:0] res;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/core/stc_front.sv =====
`timescale 1ns / 1ps

module stc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_byte,
  input  logic             end_of_buffer,
  input  logic [63:0]      separator_mask,
  input  stc_pkg::q_status_t q_status,
  output logic             push,
  output stc_pkg::bundle_t push_data
);

  stc_pkg::mode_t   mode;
  stc_pkg::mode_t   mode_next;
  stc_pkg::bundle_t bundle;
  logic             accept;
  logic             is_sep;

  assign is_sep   = (in_byte[7:6] == 2'b00) && separator_mask[in_byte[5:0]];
  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;

  always_comb begin
    logic [1:0] n;
    n         = 2'd0;
    bundle    = '0;
    mode_next = mode;
    unique case (mode)
      stc_pkg::MODE_SLASH: begin
        if (in_byte == stc_pkg::CH_SLASH) begin
          mode_next = stc_pkg::MODE_COMMENT;
        end else begin
          bundle.res[n] = '{kind: stc_pkg::KIND_BYTE, data: stc_pkg::CH_SLASH};
          n = n + 2'd1;
          if (is_sep) begin
            bundle.res[n] = '{kind: stc_pkg::KIND_MARK, data: 8'h00};
            mode_next = stc_pkg::MODE_SKIP;
          end else begin
            bundle.res[n] = '{kind: stc_pkg::KIND_BYTE, data: in_byte};
            mode_next = stc_pkg::MODE_WORD;
          end
          n = n + 2'd1;
        end
      end
      stc_pkg::MODE_COMMENT: begin
        if (in_byte == stc_pkg::CH_NEWLINE) begin
          mode_next = stc_pkg::MODE_SKIP;
        end
      end
      stc_pkg::MODE_QUOTE: begin
        if (in_byte == stc_pkg::CH_QUOTE) begin
          bundle.res[n] = '{kind: stc_pkg::KIND_MARK, data: 8'h00};
          mode_next = stc_pkg::MODE_SKIP;
        end else begin
          bundle.res[n] = '{kind: stc_pkg::KIND_BYTE, data: in_byte};
        end
        n = n + 2'd1;
      end
      stc_pkg::MODE_WORD: begin
        if (is_sep) begin
          bundle.res[n] = '{kind: stc_pkg::KIND_MARK, data: 8'h00};
          mode_next = stc_pkg::MODE_SKIP;
        end else begin
          bundle.res[n] = '{kind: stc_pkg::KIND_BYTE, data: in_byte};
          mode_next = stc_pkg::MODE_WORD;
        end
        n = n + 2'd1;
      end
      default: begin
        if (is_sep) begin
          mode_next = stc_pkg::MODE_SKIP;
        end else if (in_byte == stc_pkg::CH_SLASH) begin
          mode_next = stc_pkg::MODE_SLASH;
        end else if (in_byte == stc_pkg::CH_QUOTE) begin
          mode_next = stc_pkg::MODE_QUOTE;
        end else begin
          bundle.res[n] = '{kind: stc_pkg::KIND_BYTE, data: in_byte};
          n = n + 2'd1;
          mode_next = stc_pkg::MODE_WORD;
        end
      end
    endcase

    if (end_of_buffer) begin
      if (mode_next == stc_pkg::MODE_WORD || mode_next == stc_pkg::MODE_QUOTE) begin
        bundle.res[n] = '{kind: stc_pkg::KIND_MARK, data: 8'h00};
        n = n + 2'd1;
      end else if (mode_next == stc_pkg::MODE_SLASH) begin
        bundle.res[n] = '{kind: stc_pkg::KIND_BYTE, data: stc_pkg::CH_SLASH};
        n = n + 2'd1;
        bundle.res[n] = '{kind: stc_pkg::KIND_MARK, data: 8'h00};
        n = n + 2'd1;
      end
      mode_next = stc_pkg::MODE_SKIP;
    end
    bundle.cnt = n;
  end

  assign push      = accept && (bundle.cnt != 2'd0);
  assign push_data = bundle;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= stc_pkg::MODE_SKIP;
    end else if (accept) begin
      mode <= mode_next;
    end
  end

endmodule

// ===== rtl/core/stc_queue.sv =====
`timescale 1ns / 1ps

module stc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  stc_pkg::bundle_t   push_data,
  input  logic               pop,
  output stc_pkg::bundle_t   head,
  output stc_pkg::q_status_t status
);

  localparam int unsigned PtrW = $clog2(stc_pkg::QDepth);
  localparam int unsigned CntW = $clog2(stc_pkg::QDepth + 1);

  stc_pkg::bundle_t               entries [stc_pkg::QDepth];
  logic [PtrW-1:0]                wr_ptr;
  logic [PtrW-1:0]                rd_ptr;
  logic [CntW-1:0]                count;

  assign status.full  = (count == CntW'(stc_pkg::QDepth));
  assign status.empty = (count == '0);
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(stc_pkg::QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(stc_pkg::QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/stc_back.sv =====
`timescale 1ns / 1ps

module stc_back (
  input  logic               clk,
  input  logic               rst,
  input  stc_pkg::bundle_t   head,
  input  stc_pkg::q_status_t q_status,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               kind,
  output logic [7:0]         out_byte,
  output logic               run_last
);

  logic [1:0]    idx;
  stc_pkg::res_t cur;
  logic          accept;

  assign cur       = head.res[idx];
  assign out_valid = !q_status.empty;
  assign kind      = cur.kind;
  assign out_byte  = cur.data;
  assign run_last  = (idx == head.cnt - 2'd1);
  assign accept    = out_valid && !out_stall;
  assign pop       = accept && run_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (accept) begin
      idx <= run_last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

// ===== rtl/core/separator_tokenizer_quotes_comments.sv =====
`timescale 1ns / 1ps

// Streaming tokenizer: one text byte per request, results are token bytes and
// end-of-token marks, run_last flagging the final result of each input byte.
// A byte giving at most one result is taken every cycle while the queue has room;
// a byte giving two or three results (lone slash, end of buffer) is sent out one
// result at a time, absorbed by a two-entry queue between the mode machine and
// the serialiser. Separator mask is a 64-bit register at address 0; the user
// must write it only while idle, as the block itself does not enforce this.
module separator_tokenizer_quotes_comments (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_buffer,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [7:0]  out_byte,
  output logic        run_last
);

  logic [63:0]        separator_mask;
  logic               push;
  logic               pop;
  stc_pkg::bundle_t   push_data;
  stc_pkg::bundle_t   head;
  stc_pkg::q_status_t q_status;

  assign pready = 1'b1;
  assign prdata = (paddr[3:3] == stc_pkg::REG_SEPARATOR_MASK) ? separator_mask : 64'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      separator_mask <= stc_pkg::MASK_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[3:3] == stc_pkg::REG_SEPARATOR_MASK) begin
      separator_mask <= pwdata;
    end
  end

  stc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .end_of_buffer  (end_of_buffer),
    .separator_mask (separator_mask),
    .q_status       (q_status),
    .push           (push),
    .push_data      (push_data)
  );

  stc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  stc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .out_byte  (out_byte),
    .run_last  (run_last)
  );

endmodule

// ===== rtl/core/stc_checker.sv =====
`timescale 1ns / 1ps

module stc_checker (
  input logic       clk,
  input logic       rst,
  input logic       pready,
  input logic       out_valid,
  input logic       out_stall,
  input logic       kind,
  input logic [7:0] out_byte,
  input logic       run_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(out_byte)
      && $stable(run_last))
    else $error("stalled result changed");

  a_mark_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> out_byte == 8'h00)
    else $error("end-of-token mark carries a byte");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready dropped");

endmodule

bind separator_tokenizer_quotes_comments stc_checker u_stc_checker (
  .clk       (clk),
  .rst       (rst),
  .pready    (pready),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .kind      (kind),
  .out_byte  (out_byte),
  .run_last  (run_last)
);
